// ----- src/hbs_pkg.sv -----
// ----------------------------------------------------------------------------
// hbs_pkg: shared constants and types of the heightfield bilinear sampler
// grid geometry, field widths, bank layout and register map
// ----------------------------------------------------------------------------
`default_nettype none

package hbs_pkg;

  // grid geometry
  localparam int GRID_WIDTH  = 64;
  localparam int GRID_DEPTH  = 64;
  localparam int COL_W       = $clog2(GRID_WIDTH);
  localparam int ROW_W       = $clog2(GRID_DEPTH);

  // four banks split by column and row parity, so the four corners of a
  // cell always fall in different banks
  localparam int NUM_BANKS   = 4;
  localparam int BANK_SEL_W  = 2;
  localparam int BANK_AW     = COL_W + ROW_W - 2;
  localparam int BANK_DEPTH  = 2 ** BANK_AW;

  // field widths
  localparam int HEIGHT_W    = 16;
  localparam int FRAC_W      = 8;
  localparam int INV_W       = 16;
  localparam int POS_X_W     = 20;
  localparam int POS_Z_W     = 21;

  // datapath widths
  localparam int GX_W        = POS_X_W + INV_W;
  localparam int GZ_W        = POS_Z_W + INV_W;
  localparam int INT_SHIFT   = 2 * FRAC_W;
  localparam int CELLX_W     = GX_W - INT_SHIFT;
  localparam int CELLZ_W     = GZ_W - INT_SHIFT;
  localparam int WGT_W       = FRAC_W + 1;
  localparam int PROD_W      = HEIGHT_W + WGT_W;
  localparam int BLEND_W     = PROD_W + WGT_W;
  localparam int ROUND_BIAS  = 2 ** (INT_SHIFT - 1);

  // configuration port
  localparam int PADDR_W     = 3;
  localparam int PDATA_W     = 32;
  localparam int REG_IDX_W   = PADDR_W - 2;
  localparam logic [REG_IDX_W-1:0] REG_INV_SPACING = REG_IDX_W'(0);
  localparam logic [INV_W-1:0]     INV_RESET       = INV_W'(256);

  typedef enum logic [0:0] {
    OP_WRITE = 1'b0,
    OP_QUERY = 1'b1
  } op_e;

endpackage

`default_nettype wire

// ----- src/hbs_if.sv -----
// ----------------------------------------------------------------------------
// hbs_if: valid/ready channels of the heightfield bilinear sampler
// input words (writes and queries) and result words
// ----------------------------------------------------------------------------
`default_nettype none

interface hbs_in_if;
  import hbs_pkg::*;

  logic                       valid;
  logic                       ready;
  logic                       op;
  logic [COL_W-1:0]           write_col;
  logic [ROW_W-1:0]           write_row;
  logic [HEIGHT_W-1:0]        write_height;
  logic [POS_X_W-1:0]         pos_x;
  logic signed [POS_Z_W-1:0]  pos_z;

  modport source (
    output valid, op, write_col, write_row, write_height, pos_x, pos_z,
    input  ready
  );

  modport sink (
    input  valid, op, write_col, write_row, write_height, pos_x, pos_z,
    output ready
  );
endinterface

interface hbs_out_if;
  import hbs_pkg::*;

  logic                valid;
  logic                ready;
  logic [HEIGHT_W-1:0] height;
  logic                out_of_range;

  modport source (
    output valid, height, out_of_range,
    input  ready
  );

  modport sink (
    input  valid, height, out_of_range,
    output ready
  );
endinterface

`default_nettype wire

// ----- src/heightfield_bilinear_sampler_core.sv -----
// ----------------------------------------------------------------------------
// heightfield_bilinear_sampler_core: bilinear height lookup over a 64x64 grid
// a query result word passes through s1 to s6 and then the output register
// throughput: one word per cycle unless the result channel stalls; four parity banks give all corners in one read
// writes give no result and land in the store as they leave s2
// reset: pipeline valids cleared, inverse spacing set to 1.0; store not cleared
// ----------------------------------------------------------------------------
`default_nettype none

module heightfield_bilinear_sampler_core (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  hbs_in_if.sink                      item_i,
  hbs_out_if.source                   result_o,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [hbs_pkg::PADDR_W-1:0] paddr,
  input  logic [hbs_pkg::PDATA_W-1:0] pwdata,
  output logic [hbs_pkg::PDATA_W-1:0] prdata,
  output logic                        pready
);
  import hbs_pkg::*;

  // --------------------------------------------------------------------------
  // configuration
  // --------------------------------------------------------------------------
  logic [INV_W-1:0] inv_spacing;

  hbs_apb_regs u_regs (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .inv_spacing_o (inv_spacing)
  );

  // --------------------------------------------------------------------------
  // pipeline handshake
  // s1 input register, s2 scaled position and store access, s3 corner data,
  // s4 horizontal weights, s5 row sums, s6 vertical weights, then the output
  // register. each stage moves when it is empty or its successor moves, so
  // bubbles close up and the input keeps flowing while a result waits, until the bubbles are filled.
  // --------------------------------------------------------------------------
  logic s1_vld_q, s2_vld_q, s3_vld_q, s4_vld_q, s5_vld_q, s6_vld_q, out_vld_q;
  logic s1_rdy, s2_rdy, s3_rdy, s4_rdy, s5_rdy, s6_rdy, out_rdy;

  op_e  s1_op_q, s2_op_q;

  assign out_rdy = !out_vld_q || result_o.ready;
  assign s6_rdy  = !s6_vld_q || out_rdy;
  assign s5_rdy  = !s5_vld_q || s6_rdy;
  assign s4_rdy  = !s4_vld_q || s5_rdy;
  assign s3_rdy  = !s3_vld_q || s4_rdy;
  // a write leaves s2 straight into the store and needs no room in s3
  assign s2_rdy  = !s2_vld_q || (s2_op_q == OP_WRITE) || s3_rdy;
  assign s1_rdy  = !s1_vld_q || s2_rdy;

  assign item_i.ready = s1_rdy;

  logic s2_fire;
  logic s2_query_fire;
  assign s2_fire       = s2_vld_q && s2_rdy;
  assign s2_query_fire = s2_vld_q && (s2_op_q == OP_QUERY) && s3_rdy;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q  <= 1'b0;
      s2_vld_q  <= 1'b0;
      s3_vld_q  <= 1'b0;
      s4_vld_q  <= 1'b0;
      s5_vld_q  <= 1'b0;
      s6_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      if (s1_rdy)  s1_vld_q  <= item_i.valid;
      if (s2_rdy)  s2_vld_q  <= s1_vld_q;
      if (s3_rdy)  s3_vld_q  <= s2_vld_q && (s2_op_q == OP_QUERY);
      if (s4_rdy)  s4_vld_q  <= s3_vld_q;
      if (s5_rdy)  s5_vld_q  <= s4_vld_q;
      if (s6_rdy)  s6_vld_q  <= s5_vld_q;
      if (out_rdy) out_vld_q <= s6_vld_q;
    end
  end

  // --------------------------------------------------------------------------
  // s1: input register; z is negated here so the multiplier sees a magnitude
  // --------------------------------------------------------------------------
  logic [COL_W-1:0]    s1_wcol_q;
  logic [ROW_W-1:0]    s1_wrow_q;
  logic [HEIGHT_W-1:0] s1_wh_q;
  logic [POS_X_W-1:0]  s1_px_q;
  logic [POS_Z_W-1:0]  s1_nz_q;
  logic                s1_zpos_q;

  logic [POS_Z_W-1:0]  z_bits;
  logic [POS_Z_W-1:0]  nz_d;
  logic                zpos_d;

  assign z_bits = item_i.pos_z;
  // the most negative code comes out as 2^20, its true magnitude
  assign nz_d   = (~z_bits) + POS_Z_W'(1);
  // z above zero lies off the map
  assign zpos_d = !z_bits[POS_Z_W-1] && (z_bits != '0);

  always_ff @(posedge clk_i) begin
    if (item_i.valid && s1_rdy) begin
      s1_op_q   <= op_e'(item_i.op);
      s1_wcol_q <= item_i.write_col;
      s1_wrow_q <= item_i.write_row;
      s1_wh_q   <= item_i.write_height;
      s1_px_q   <= item_i.pos_x;
      s1_nz_q   <= nz_d;
      s1_zpos_q <= zpos_d;
    end
  end

  // --------------------------------------------------------------------------
  // s2: scaled position in grid units (integer cell, 8-bit fraction)
  // --------------------------------------------------------------------------
  logic [GX_W-1:0]     s2_gx_q;
  logic [GZ_W-1:0]     s2_gz_q;
  logic [COL_W-1:0]    s2_wcol_q;
  logic [ROW_W-1:0]    s2_wrow_q;
  logic [HEIGHT_W-1:0] s2_wh_q;
  logic                s2_zpos_q;

  always_ff @(posedge clk_i) begin
    if (s1_vld_q && s2_rdy) begin
      s2_op_q   <= s1_op_q;
      s2_gx_q   <= GX_W'(s1_px_q) * GX_W'(inv_spacing);
      s2_gz_q   <= GZ_W'(s1_nz_q) * GZ_W'(inv_spacing);
      s2_wcol_q <= s1_wcol_q;
      s2_wrow_q <= s1_wrow_q;
      s2_wh_q   <= s1_wh_q;
      s2_zpos_q <= s1_zpos_q;
    end
  end

  logic [CELLX_W-1:0] s2_cellx;
  logic [CELLZ_W-1:0] s2_cellz;
  logic [FRAC_W-1:0]  s2_tx;
  logic [FRAC_W-1:0]  s2_ty;
  logic               s2_oor;
  logic [COL_W-1:0]   s2_c0, s2_c1;
  logic [ROW_W-1:0]   s2_r0, s2_r1;

  assign s2_cellx = s2_gx_q[GX_W-1:INT_SHIFT];
  assign s2_cellz = s2_gz_q[GZ_W-1:INT_SHIFT];
  assign s2_tx    = s2_gx_q[FRAC_W +: FRAC_W];
  assign s2_ty    = s2_gz_q[FRAC_W +: FRAC_W];
  // far corner must still be on the grid
  assign s2_oor   = s2_zpos_q
                 || (s2_cellx >= CELLX_W'(GRID_WIDTH - 1))
                 || (s2_cellz >= CELLZ_W'(GRID_DEPTH - 1));

  assign s2_c0 = s2_cellx[COL_W-1:0];
  assign s2_c1 = s2_c0 + COL_W'(1);
  assign s2_r0 = s2_cellz[ROW_W-1:0];
  assign s2_r1 = s2_r0 + ROW_W'(1);

  // --------------------------------------------------------------------------
  // height store: bank {row[0], col[0]}, address {row >> 1, col >> 1}
  // writes and reads both issue from s2, so program order holds by itself
  // --------------------------------------------------------------------------
  logic [NUM_BANKS-1:0]  bank_we;
  logic [NUM_BANKS-1:0]  bank_re;
  logic [BANK_AW-1:0]    bank_waddr;
  logic [BANK_SEL_W-1:0] wr_bank;
  logic [HEIGHT_W-1:0]   bank_rdata [NUM_BANKS];

  assign wr_bank    = {s2_wrow_q[0], s2_wcol_q[0]};
  assign bank_waddr = {s2_wrow_q[ROW_W-1:1], s2_wcol_q[COL_W-1:1]};

  for (genvar b = 0; b < NUM_BANKS; b++) begin : g_bank
    localparam logic CP = 1'(b % 2);
    localparam logic RP = 1'(b / 2);

    logic [COL_W-1:0]   col_sel;
    logic [ROW_W-1:0]   row_sel;
    logic [BANK_AW-1:0] raddr;

    // pick whichever of col, col+1 (row, row+1) has this bank's parity
    assign col_sel = (s2_c0[0] == CP) ? s2_c0 : s2_c1;
    assign row_sel = (s2_r0[0] == RP) ? s2_r0 : s2_r1;
    assign raddr   = {row_sel[ROW_W-1:1], col_sel[COL_W-1:1]};

    assign bank_we[b] = s2_fire && (s2_op_q == OP_WRITE)
                     && (wr_bank == BANK_SEL_W'(b));
    assign bank_re[b] = s2_query_fire;

    hbs_ram #(
      .WIDTH (HEIGHT_W),
      .DEPTH (BANK_DEPTH)
    ) u_bank (
      .clk_i   (clk_i),
      .we_i    (bank_we[b]),
      .waddr_i (bank_waddr),
      .wdata_i (s2_wh_q),
      .re_i    (bank_re[b]),
      .raddr_i (raddr),
      .rdata_o (bank_rdata[b])
    );
  end

  // --------------------------------------------------------------------------
  // s3: corner heights out of the banks; route each to its corner
  // --------------------------------------------------------------------------
  logic [FRAC_W-1:0] s3_tx_q, s3_ty_q;
  logic              s3_oor_q, s3_cp_q, s3_rp_q;

  always_ff @(posedge clk_i) begin
    if (s2_query_fire) begin
      s3_tx_q  <= s2_tx;
      s3_ty_q  <= s2_ty;
      s3_oor_q <= s2_oor;
      s3_cp_q  <= s2_c0[0];
      s3_rp_q  <= s2_r0[0];
    end
  end

  logic [HEIGHT_W-1:0] h00, h01, h10, h11;
  logic [WGT_W-1:0]    wx0, wx1;

  assign h00 = bank_rdata[{s3_rp_q,  s3_cp_q}];
  assign h01 = bank_rdata[{s3_rp_q, ~s3_cp_q}];
  assign h10 = bank_rdata[{~s3_rp_q,  s3_cp_q}];
  assign h11 = bank_rdata[{~s3_rp_q, ~s3_cp_q}];

  assign wx1 = WGT_W'(s3_tx_q);
  assign wx0 = WGT_W'(2 ** FRAC_W) - wx1;

  // --------------------------------------------------------------------------
  // s4: four corner products with the column weights
  // --------------------------------------------------------------------------
  logic [PROD_W-1:0] s4_p00_q, s4_p01_q, s4_p10_q, s4_p11_q;
  logic [FRAC_W-1:0] s4_ty_q;
  logic              s4_oor_q;

  always_ff @(posedge clk_i) begin
    if (s3_vld_q && s4_rdy) begin
      s4_p00_q <= PROD_W'(h00) * PROD_W'(wx0);
      s4_p01_q <= PROD_W'(h01) * PROD_W'(wx1);
      s4_p10_q <= PROD_W'(h10) * PROD_W'(wx0);
      s4_p11_q <= PROD_W'(h11) * PROD_W'(wx1);
      s4_ty_q  <= s3_ty_q;
      s4_oor_q <= s3_oor_q;
    end
  end

  // --------------------------------------------------------------------------
  // s5: near and far row blends
  // --------------------------------------------------------------------------
  logic [PROD_W-1:0] s5_top_q, s5_bot_q;
  logic [FRAC_W-1:0] s5_ty_q;
  logic              s5_oor_q;

  always_ff @(posedge clk_i) begin
    if (s4_vld_q && s5_rdy) begin
      s5_top_q <= s4_p00_q + s4_p01_q;
      s5_bot_q <= s4_p10_q + s4_p11_q;
      s5_ty_q  <= s4_ty_q;
      s5_oor_q <= s4_oor_q;
    end
  end

  // --------------------------------------------------------------------------
  // s6: row weights
  // --------------------------------------------------------------------------
  logic [BLEND_W-1:0] s6_mt_q, s6_mb_q;
  logic               s6_oor_q;
  logic [WGT_W-1:0]   wy0, wy1;

  assign wy1 = WGT_W'(s5_ty_q);
  assign wy0 = WGT_W'(2 ** FRAC_W) - wy1;

  always_ff @(posedge clk_i) begin
    if (s5_vld_q && s6_rdy) begin
      s6_mt_q  <= BLEND_W'(s5_top_q) * BLEND_W'(wy0);
      s6_mb_q  <= BLEND_W'(s5_bot_q) * BLEND_W'(wy1);
      s6_oor_q <= s5_oor_q;
    end
  end

  // --------------------------------------------------------------------------
  // output register: round half up, drop to zero off the map
  // --------------------------------------------------------------------------
  logic [BLEND_W-1:0]  blend_sum;
  logic [HEIGHT_W-1:0] out_height_q;
  logic                out_oor_q;

  assign blend_sum = s6_mt_q + s6_mb_q + BLEND_W'(ROUND_BIAS);

  always_ff @(posedge clk_i) begin
    if (s6_vld_q && out_rdy) begin
      out_height_q <= s6_oor_q ? '0 : blend_sum[INT_SHIFT +: HEIGHT_W];
      out_oor_q    <= s6_oor_q;
    end
  end

  assign result_o.valid        = out_vld_q;
  assign result_o.height       = out_height_q;
  assign result_o.out_of_range = out_oor_q;

`ifndef SYNTHESIS
  // a write and a corner read never share a cycle: both leave from s2
  a_no_wr_rd_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !((|bank_we) && (|bank_re)))
    else $error("store write and read issued in the same cycle");

  a_one_bank_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0(bank_we))
    else $error("more than one bank written");

  a_oor_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && out_oor_q) |-> (out_height_q == '0))
    else $error("out of range result with non-zero height");

  a_corner_stage_moves: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s3_vld_q && s4_rdy) |=> s4_vld_q)
    else $error("corner data lost between s3 and s4");
`endif

endmodule

`default_nettype wire

// ----- src/hbs_ram.sv -----
// ----------------------------------------------------------------------------
// hbs_ram: generic single-write, single-read synchronous RAM
// read data registered, held while re_i is low
// ----------------------------------------------------------------------------
`default_nettype none

module hbs_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ----- src/hbs_apb_regs.sv -----
// ----------------------------------------------------------------------------
// hbs_apb_regs: configuration register block
// holds the inverse grid spacing, written and read over the apb port
// ----------------------------------------------------------------------------
`default_nettype none

module hbs_apb_regs (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [hbs_pkg::PADDR_W-1:0]   paddr,
  input  logic [hbs_pkg::PDATA_W-1:0]   pwdata,
  output logic [hbs_pkg::PDATA_W-1:0]   prdata,
  output logic                          pready,
  output logic [hbs_pkg::INV_W-1:0]     inv_spacing_o
);
  import hbs_pkg::*;

  logic [REG_IDX_W-1:0] reg_idx;
  logic                 wr_en;
  logic [INV_W-1:0]     inv_q;
  logic [INV_W-1:0]     inv_d;

  assign reg_idx = paddr[PADDR_W-1:2];
  assign wr_en   = psel && penable && pwrite;
  assign pready  = 1'b1;

  always_comb begin
    inv_d = inv_q;
    unique case (reg_idx)
      REG_INV_SPACING: if (wr_en) begin
        inv_d = pwdata[INV_W-1:0];
      end
      default: inv_d = inv_q;
    endcase
  end

  always_comb begin
    unique case (reg_idx)
      REG_INV_SPACING: prdata = PDATA_W'(inv_q);
      default:         prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inv_q <= INV_RESET;
    end else begin
      inv_q <= inv_d;
    end
  end

  assign inv_spacing_o = inv_q;

endmodule

`default_nettype wire
